>>> rtl/bur_pkg.sv
package bur_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int TICK_W         = 16;
    localparam int CFG_IDX_W      = 2;

    localparam logic [TICK_W-1:0] HOLD_TICKS_RST   = 16'd1000;
    localparam logic [TICK_W-1:0] WINDOW_TICKS_RST = 16'd3000;

    typedef enum logic [1:0] {
        OP_STATUS  = 2'd0,
        OP_BUTTONS = 2'd1,
        OP_TICK    = 2'd2,
        OP_UNUSED  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        LED_OFF     = 2'd0,
        LED_ON      = 2'd1,
        LED_FLASH   = 2'd2,
        LED_STANDBY = 2'd3
    } t_led;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_CHECK  = 3'd1,
        CMD_ROUTER = 3'd2,
        CMD_MODEM  = 3'd3,
        CMD_HARD   = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        M_CHECK    = 3'd0,
        M_FAIL     = 3'd1,
        M_MODEM    = 3'd2,
        M_CONN     = 3'd3,
        M_ROUTER   = 3'd4,
        M_PERIODIC = 3'd5,
        M_UNLOCK   = 3'd6
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PER_ROUTER = 2'd0,
        CFG_PER_MODEM  = 2'd1,
        CFG_HOLD       = 2'd2,
        CFG_WINDOW     = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        RT_CHECK   = 3'd0,
        RT_DISCON  = 3'd1,
        RT_FAILED  = 3'd2,
        RT_MODEM   = 3'd3,
        RT_NONE    = 3'd4,
        RT_ROUTER  = 3'd5,
        RT_ROUTER1 = 3'd6,
        RT_PERIOD  = 3'd7
    } t_rtype;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] recovery_type;
        logic       unlock_pressed;
        logic       router_pressed;
        logic       modem_pressed;
        logic       check_pressed;
    } t_in_req;

    typedef struct packed {
        logic [1:0] operation_led;
        logic [1:0] unlock_led;
        logic [1:0] modem_led;
        logic [1:0] router_led;
        logic [2:0] command;
        logic [2:0] mode_out;
    } t_out_rsp;

    function automatic t_mode mode_of_type(input logic [2:0] rtype);
        t_mode m;
        unique case (t_rtype'(rtype))
            RT_CHECK:   m = M_CHECK;
            RT_DISCON:  m = M_FAIL;
            RT_FAILED:  m = M_FAIL;
            RT_MODEM:   m = M_MODEM;
            RT_NONE:    m = M_CONN;
            RT_ROUTER:  m = M_ROUTER;
            RT_ROUTER1: m = M_ROUTER;
            RT_PERIOD:  m = M_PERIODIC;
            default:    m = M_CHECK;
        endcase
        return m;
    endfunction

endpackage

>>> rtl/button_unlock_recovery_panel_fsm.sv
// Front-panel controller for a network recovery box. Each request carries one event (a
// recovery-status change, a fresh sample of the four buttons, or a 1 ms tick) and yields exactly
// one result with the four LED codes, the mode after the event and a command. A request is
// accepted every cycle while the output register is empty or being drained; its result appears
// in the output register on the following cycle. The whole event is resolved by combinational
// next-state logic, so the sustained rate is one event per clock while i_out_ready stays high.
// Unlock takes two stages: the unlock button alone held for hold_ticks ticks, then exactly one
// button pressed within window_ticks ticks (router, modem, or check for a hard reset).
// Configuration writes take effect on the next event.
module button_unlock_recovery_panel_fsm #(
    parameter int TIMER_BITS = bur_pkg::TIMER_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  bur_pkg::t_in_req                i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output bur_pkg::t_out_rsp               o_out,
    input  logic                            i_cfg_we,
    input  logic [bur_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bur_pkg::TICK_W-1:0]      i_cfg_data
);
    import bur_pkg::*;

    logic                  r_per_router;
    logic                  r_per_modem;
    logic [TICK_W-1:0]     r_hold;
    logic [TICK_W-1:0]     r_window;

    t_mode                 r_mode, n_mode;
    logic                  r_conn, n_conn;
    logic                  r_unlocked, n_unlocked;
    logic [TIMER_BITS-1:0] r_count, n_count;
    t_led                  r_led_op, n_led_op;
    t_led                  r_led_ul, n_led_ul;
    t_led                  r_led_mr, n_led_mr;
    t_led                  r_led_rr, n_led_rr;
    t_cmd                  n_cmd;

    logic                  r_out_valid;
    t_out_rsp              r_out;

    logic                  w_accept;
    logic                  w_do_enter;
    t_mode                 w_target;
    t_mode                 w_ret_mode;
    logic [31:0]           w_hold32;
    logic [31:0]           w_window32;
    logic                  ul, rr, mr, cc;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Tick loads are cut to the timer width, as a narrow hardware timer would.
    assign w_hold32   = {16'b0, r_hold};
    assign w_window32 = {16'b0, r_window};

    assign ul = i_in.unlock_pressed;
    assign rr = i_in.router_pressed;
    assign mr = i_in.modem_pressed;
    assign cc = i_in.check_pressed;

    assign w_ret_mode = r_conn ? M_CONN : M_FAIL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_per_router <= 1'b0;
            r_per_modem  <= 1'b0;
            r_hold       <= HOLD_TICKS_RST;
            r_window     <= WINDOW_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PER_ROUTER: r_per_router <= i_cfg_data[0];
                CFG_PER_MODEM:  r_per_modem  <= i_cfg_data[0];
                CFG_HOLD:       r_hold       <= i_cfg_data;
                CFG_WINDOW:     r_window     <= i_cfg_data;
                default:        r_hold       <= r_hold;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_CHECK;
            r_conn     <= 1'b0;
            r_unlocked <= 1'b0;
            r_count    <= '0;
            r_led_op   <= LED_FLASH;
            r_led_ul   <= LED_STANDBY;
            r_led_mr   <= LED_STANDBY;
            r_led_rr   <= LED_STANDBY;
        end else if (w_accept) begin
            r_mode     <= n_mode;
            r_conn     <= n_conn;
            r_unlocked <= n_unlocked;
            r_count    <= n_count;
            r_led_op   <= n_led_op;
            r_led_ul   <= n_led_ul;
            r_led_mr   <= n_led_mr;
            r_led_rr   <= n_led_rr;
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_conn     = r_conn;
        n_unlocked = r_unlocked;
        n_count    = r_count;
        n_led_op   = r_led_op;
        n_led_ul   = r_led_ul;
        n_led_mr   = r_led_mr;
        n_led_rr   = r_led_rr;
        n_cmd      = CMD_NONE;
        w_do_enter = 1'b0;
        w_target   = r_mode;

        unique case (t_op'(i_in.opcode))
            OP_STATUS: begin
                w_do_enter = 1'b1;
                w_target   = mode_of_type(i_in.recovery_type);
            end
            OP_BUTTONS: begin
                if (r_mode == M_CONN || r_mode == M_FAIL) begin
                    n_conn = (r_mode == M_CONN);
                    if (ul && !rr && !mr && !cc) begin
                        w_do_enter = 1'b1;
                        w_target   = M_UNLOCK;
                    end else if (cc && !ul && !rr && !mr) begin
                        n_cmd = CMD_CHECK;
                    end
                end else if (r_mode == M_UNLOCK) begin
                    if (!r_unlocked) begin
                        if (!ul || mr || rr || cc) begin
                            w_do_enter = 1'b1;
                            w_target   = w_ret_mode;
                        end
                    end else if (!ul && !mr && rr && !cc) begin
                        n_cmd = CMD_ROUTER;
                    end else if (!ul && mr && !rr && !cc) begin
                        n_cmd = CMD_MODEM;
                    end else if (cc && !ul && !mr && !rr) begin
                        n_cmd      = CMD_HARD;
                        w_do_enter = 1'b1;
                        w_target   = w_ret_mode;
                    end
                end
            end
            OP_TICK: begin
                if (r_mode == M_UNLOCK) begin
                    // A zero load behaves like one: the timer fires on the next tick.
                    if (r_count <= TIMER_BITS'(1)) begin
                        if (r_unlocked) begin
                            w_do_enter = 1'b1;
                            w_target   = w_ret_mode;
                        end else begin
                            n_unlocked = 1'b1;
                            n_led_ul   = LED_ON;
                            n_led_mr   = LED_ON;
                            n_led_rr   = LED_ON;
                            n_count    = w_window32[TIMER_BITS-1:0];
                        end
                    end else begin
                        n_count = r_count - TIMER_BITS'(1);
                    end
                end
            end
            default: begin
                n_cmd = CMD_NONE;
            end
        endcase

        // Mode entry runs even when the same mode is entered again.
        if (w_do_enter) begin
            n_mode     = w_target;
            n_unlocked = 1'b0;
            n_count    = '0;
            unique case (w_target)
                M_CHECK: begin
                    n_led_op = LED_FLASH;
                    n_led_ul = LED_STANDBY;
                    n_led_mr = LED_STANDBY;
                    n_led_rr = LED_STANDBY;
                end
                M_FAIL: begin
                    n_led_op = LED_OFF;
                    n_led_ul = LED_STANDBY;
                    n_led_mr = LED_STANDBY;
                    n_led_rr = LED_STANDBY;
                end
                M_CONN: begin
                    n_led_op = LED_ON;
                    n_led_ul = LED_STANDBY;
                    n_led_mr = LED_STANDBY;
                    n_led_rr = LED_STANDBY;
                end
                M_ROUTER: begin
                    n_led_op = LED_OFF;
                    n_led_ul = LED_OFF;
                    n_led_mr = LED_OFF;
                    n_led_rr = LED_FLASH;
                end
                M_MODEM: begin
                    n_led_op = LED_OFF;
                    n_led_ul = LED_OFF;
                    n_led_mr = LED_FLASH;
                    n_led_rr = LED_OFF;
                end
                M_PERIODIC: begin
                    n_led_op = LED_OFF;
                    n_led_ul = LED_OFF;
                    n_led_mr = r_per_modem ? LED_FLASH : LED_OFF;
                    n_led_rr = r_per_router ? LED_FLASH : LED_OFF;
                end
                M_UNLOCK: begin
                    n_led_op = r_led_op;
                    n_led_ul = LED_OFF;
                    n_led_mr = LED_STANDBY;
                    n_led_rr = LED_STANDBY;
                    n_count  = w_hold32[TIMER_BITS-1:0];
                end
                default: begin
                    n_mode = w_target;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out.operation_led <= n_led_op;
            r_out.unlock_led    <= n_led_ul;
            r_out.modem_led     <= n_led_mr;
            r_out.router_led    <= n_led_rr;
            r_out.command       <= n_cmd;
            r_out.mode_out      <= n_mode;
        end
    end

`ifndef ASSERT_OFF
    a_count_only_unlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != M_UNLOCK |-> r_count == '0)
        else $error("countdown running outside unlock mode");

    a_unlocked_only_unlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_unlocked |-> r_mode == M_UNLOCK)
        else $error("unlocked flag set outside unlock mode");

    a_hard_reset_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && n_cmd == CMD_HARD
        |=> r_out.mode_out == M_CONN || r_out.mode_out == M_FAIL)
        else $error("hard reset did not return to connected or failure");

    a_accept_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid && r_out.mode_out == r_mode)
        else $error("accepted request did not produce a matching result");
`endif

endmodule
